### rtl/sorted_set_insert_delete_top_macros.svh
// ----------------------------------------------------------------------------
// Sorted set assertion macros
// Shared concurrent assertion forms for the sorted set block.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_DELETE_TOP_MACROS_SVH
`define SORTED_SET_INSERT_DELETE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSET_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted set assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSET_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted set assertion failed");

`endif

### rtl/sset_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set package
// Types, codes and sizes shared by the sorted set cells and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sset_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;
    localparam logic [2:0] ST_ENTRY     = 3'd5;
    localparam logic [2:0] ST_EMPTY     = 3'd6;

    typedef struct packed {
        logic [1:0]          command;
        logic signed [31:0]  operand_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]          status;
        logic signed [31:0]  entry_value;
        logic [4:0]          held_count;
        logic                last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_e;

    typedef struct packed {
        logic in_use;
        logic is_first;
        logic is_last;
    } cell_pos_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_READ
    } fsm_state_e;

    function automatic logic [4:0] to_held(input logic [CNT_W-1:0] count);
        logic [CNT_W+4:0] wide;
        wide = {5'd0, count};
        return wide[4:0];
    endfunction

endpackage

`default_nettype wire

### rtl/sset_cell.sv
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one slot of the sorted array, compares it against the operand and
// takes its next value from itself, the operand, a neighbor or cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sset_cell (
    input  wire logic                 aclk,
    input  wire sset_pkg::cell_op_e   op,
    input  wire sset_pkg::cell_pos_t  pos,
    input  wire logic signed [31:0]   operand,
    input  wire logic signed [31:0]   left_value,
    input  wire logic                 left_lt,
    input  wire logic signed [31:0]   right_value,
    input  wire logic signed [31:0]   head_value,
    output logic signed [31:0]        value,
    output logic                      lt,
    output logic                      eq
);
    import sset_pkg::*;

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    assign value = value_reg;
    assign lt    = pos.in_use && (value_reg < operand);
    assign eq    = pos.in_use && (value_reg == operand);

    always_comb begin
        value_next = value_reg;
        case (op)
            CELL_INSERT: begin
                if (!lt) begin
                    value_next = (pos.is_first || left_lt) ? operand : left_value;
                end
            end
            CELL_DELETE: begin
                if (!lt) begin
                    value_next = right_value;
                end
            end
            CELL_ROTATE: begin
                value_next = pos.is_last ? head_value : right_value;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

### rtl/sorted_set_insert_delete_top.sv
// ----------------------------------------------------------------------------
// Sorted set with insert, delete and readout
// Bounded ascending set of signed values held in a row of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// Each command is taken into an operation register. An insert or delete is
// settled in the EXEC state once the output register is free: every cell
// compares its value with the operand at once and shifts toward or away from
// its neighbor, and the result is written to the output register. A readout
// passes through EXEC and then rotates the row through cell zero in the READ
// state, giving one entry per cycle while the output register is free; an
// empty set gives a single EMPTY item. A result that waits for m_ready stalls
// the command in progress. A new item is taken once the previous command has
// left the cells, even while its last result still waits in the output
// register. Unused command code three gives no result.
`default_nettype none

`include "sorted_set_insert_delete_top_macros.svh"

module sorted_set_insert_delete_top (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sset_pkg::in_item_t   s_item,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sset_pkg::out_item_t       m_item
);
    import sset_pkg::*;

    fsm_state_e          state_reg, state_next;
    in_item_t            op_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           out_reg, out_next;

    cell_op_e            cell_op;
    logic signed [31:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic                found;
    logic                full;
    logic                out_free;
    logic                read_last;

    assign s_ready  = (state_reg == FSM_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = out_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign found    = |cell_eq;
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign read_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        cell_pos_t           pos;
        logic signed [31:0]  left_value;
        logic                left_lt;
        logic signed [31:0]  right_value;

        assign pos.in_use   = (CNT_W'(i) < count_reg);
        assign pos.is_first = (i == 0);
        assign pos.is_last  = (CNT_W'(i + 1) == count_reg);

        if (i == 0) begin : g_first
            assign left_value = cell_value[0];
            assign left_lt    = 1'b0;
        end else begin : g_inner_left
            assign left_value = cell_value[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_final
            assign right_value = cell_value[i];
        end else begin : g_inner_right
            assign right_value = cell_value[i+1];
        end

        sset_cell u_cell (
            .aclk        (aclk),
            .op          (cell_op),
            .pos         (pos),
            .operand     (op_reg.operand_value),
            .left_value  (left_value),
            .left_lt     (left_lt),
            .right_value (right_value),
            .head_value  (cell_value[0]),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .eq          (cell_eq[i])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        cell_op      = CELL_HOLD;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                case (op_reg.command) inside
                    CMD_INSERT, CMD_DELETE: begin
                        if (out_free) begin
                            out_next.entry_value = op_reg.operand_value;
                            out_next.last_of_run = 1'b1;
                            if (op_reg.command == CMD_INSERT) begin
                                if (found) begin
                                    out_next.status = ST_DUPLICATE;
                                end else if (full) begin
                                    out_next.status = ST_FULL;
                                end else begin
                                    out_next.status = ST_INSERTED;
                                    cell_op         = CELL_INSERT;
                                    count_next      = count_reg + CNT_W'(1);
                                end
                            end else begin
                                if (found) begin
                                    out_next.status = ST_DELETED;
                                    cell_op         = CELL_DELETE;
                                    count_next      = count_reg - CNT_W'(1);
                                end else begin
                                    out_next.status = ST_NOTFOUND;
                                end
                            end
                            out_next.held_count = to_held(count_next);
                            m_valid_next        = 1'b1;
                            state_next          = FSM_IDLE;
                        end
                    end
                    CMD_READ: begin
                        if (count_reg == '0) begin
                            if (out_free) begin
                                out_next.status      = ST_EMPTY;
                                out_next.entry_value = '0;
                                out_next.held_count  = to_held(count_reg);
                                out_next.last_of_run = 1'b1;
                                m_valid_next         = 1'b1;
                                state_next           = FSM_IDLE;
                            end
                        end else begin
                            idx_next   = '0;
                            state_next = FSM_READ;
                        end
                    end
                    default: begin
                        state_next = FSM_IDLE;
                    end
                endcase
            end
            FSM_READ: begin
                if (out_free) begin
                    out_next.status      = ST_ENTRY;
                    out_next.entry_value = cell_value[0];
                    out_next.held_count  = to_held(count_reg);
                    out_next.last_of_run = read_last;
                    m_valid_next         = 1'b1;
                    cell_op              = CELL_ROTATE;
                    idx_next             = idx_reg + IDX_W'(1);
                    if (read_last) begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_valid && s_ready) begin
            op_reg <= s_item;
        end
    end

    `SSET_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SSET_ASSERT_NXT(a_accept_exec, aclk, aresetn, s_valid && s_ready, state_reg == FSM_EXEC)
    `SSET_ASSERT_NXT(a_insert_count, aclk, aresetn, cell_op == CELL_INSERT,
        count_reg == $past(count_reg) + CNT_W'(1))
    `SSET_ASSERT_IMP(a_read_index, aclk, aresetn, state_reg == FSM_READ,
        CNT_W'(idx_reg) < count_reg)

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted set block testbench
// Drives insert, delete and readout commands through the valid/ready input,
// keeps its own ascending copy of the set to work out every expected item,
// and checks each result item field by field under random gaps and stalls.
// ----------------------------------------------------------------------------

module tb;

    import sset_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         POOL_SIZE   = 24;
    localparam int         RANDOM_ITEMS = 150;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    in_item_t           pending_items[$];
    out_item_t          expected_results[$];
    logic signed [31:0] held_vals[CAPACITY];
    int                 held_n = 0;
    logic signed [31:0] value_pool[POOL_SIZE];

    int send_gap = 0;
    int recv_gap = 0;
    int send_quiet = 0;
    int recv_quiet = 0;
    int mismatches = 0;
    int cycle_count = 0;

    sorted_set_insert_delete_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            quiet = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 80) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return 32'sh0000_0000;
                default: return 32'shFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_item(input logic [1:0] cmd, input logic signed [31:0] value);
        in_item_t it;
        it.command       = cmd;
        it.operand_value = value;
        pending_items.push_back(it);
    endtask

    task automatic push_result(input logic [2:0] status, input logic signed [31:0] value,
                               input logic last);
        out_item_t r;
        r.status      = status;
        r.entry_value = value;
        r.held_count  = 5'(held_n);
        r.last_of_run = last;
        expected_results.push_back(r);
    endtask

    task automatic apply_command(input in_item_t it);
        int pos;
        logic found;
        logic signed [31:0] v;
        v = it.operand_value;
        pos = 0;
        while (pos < held_n && held_vals[pos] < v) pos++;
        found = (pos < held_n) && (held_vals[pos] == v);
        case (it.command)
            CMD_INSERT: begin
                if (found) begin
                    push_result(ST_DUPLICATE, v, 1'b1);
                end else if (held_n >= CAPACITY) begin
                    push_result(ST_FULL, v, 1'b1);
                end else begin
                    for (int i = held_n; i > pos; i--) held_vals[i] = held_vals[i - 1];
                    held_vals[pos] = v;
                    held_n++;
                    push_result(ST_INSERTED, v, 1'b1);
                end
            end
            CMD_DELETE: begin
                if (found) begin
                    for (int i = pos; i + 1 < held_n; i++) held_vals[i] = held_vals[i + 1];
                    held_n--;
                    push_result(ST_DELETED, v, 1'b1);
                end else begin
                    push_result(ST_NOTFOUND, v, 1'b1);
                end
            end
            CMD_READ: begin
                if (held_n == 0) begin
                    push_result(ST_EMPTY, 32'sd0, 1'b1);
                end else begin
                    for (int i = 0; i < held_n; i++)
                        push_result(ST_ENTRY, held_vals[i], i + 1 == held_n);
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item status %0d value %0d",
                                      got.status, got.entry_value));
            return;
        end
        want = expected_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_value !== want.entry_value)
            report_mismatch($sformatf("entry_value %0d, expected %0d",
                                      got.entry_value, want.entry_value));
        if (got.held_count !== want.held_count)
            report_mismatch($sformatf("held_count %0d, expected %0d",
                                      got.held_count, want.held_count));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                      got.last_of_run, want.last_of_run));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_command(s_item);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_valid  <= 1'b1;
                    s_item   <= pending_items.pop_front();
                    send_gap <= pick_gap(send_quiet);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_result(m_item);
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                recv_gap <= pick_gap(recv_quiet);
                m_ready  <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int counted;
        int phase;
        int phase_len;
        int r;
        int insert_pct;

        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = (i % 2) ? $urandom : $signed($urandom_range(0, 60)) - 30;

        add_item(CMD_READ, 32'sd0);
        add_item(CMD_UNUSED, 32'shFFFF_FFFF);
        add_item(CMD_INSERT, 32'sh7FFF_FFFF);
        add_item(CMD_INSERT, 32'sh8000_0000);
        add_item(CMD_INSERT, 32'sd0);
        add_item(CMD_INSERT, 32'shFFFF_FFFF);
        add_item(CMD_INSERT, 32'sh7FFF_FFFF);
        add_item(CMD_DELETE, 32'sd5);
        add_item(CMD_DELETE, 32'sh8000_0000);
        add_item(CMD_READ, 32'sh5555_AAAA);
        add_item(CMD_DELETE, 32'sh7FFF_FFFF);
        add_item(CMD_INSERT, 32'sh8000_0000);
        for (int i = 0; i < 13; i++) add_item(CMD_INSERT, 100 * (13 - i));
        add_item(CMD_INSERT, 32'sd0);
        add_item(CMD_INSERT, 32'sd12345);
        add_item(CMD_READ, 32'sd0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            phase      = $urandom_range(0, 2);
            phase_len  = $urandom_range(10, 30);
            insert_pct = (phase == 0) ? 85 : (phase == 1) ? 20 : 55;
            for (int k = 0; k < phase_len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    add_item(CMD_UNUSED, $urandom);
                end else begin
                    if (r < 12) add_item(CMD_READ, $urandom);
                    else if ($urandom_range(0, 99) < insert_pct)
                        add_item(CMD_INSERT, pick_value());
                    else
                        add_item(CMD_DELETE, pick_value());
                    counted++;
                end
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_valid) @(posedge aclk);
        while (expected_results.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sset_pkg.sv
rtl/sset_cell.sv
rtl/sorted_set_insert_delete_top.sv
bench/tb.sv
